FILE: src/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_PATTERN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_TEXT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_LENGTH = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } slot_type;

   typedef struct packed {
      logic load;
      logic shift_scan;
      logic shift_data;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: src/sfr_cell.sv
`default_nettype none

module sfr_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sfr_pkg::cell_ctrl_type  ctrl,
   input  wire logic                    load_sel,
   input  wire logic                    past_len,
   input  wire logic [7:0]              pat_byte,
   input  wire logic [7:0]              new_byte,
   input  wire sfr_pkg::slot_type       nbr_data,
   input  wire sfr_pkg::slot_type       nbr_scan,
   output sfr_pkg::slot_type            data_out,
   output sfr_pkg::slot_type            scan_out,
   output logic                         bad
);

   logic       data_valid_ff, data_valid_in;
   logic [7:0] data_value_ff, data_value_in;
   logic       scan_valid_ff, scan_valid_in;
   logic [7:0] scan_value_ff, scan_value_in;

   always_comb begin
      data_valid_in = data_valid_ff;
      data_value_in = data_value_ff;
      if (ctrl.clear) begin
         data_valid_in = 1'b0;
      end else if (ctrl.load && load_sel) begin
         data_valid_in = 1'b1;
         data_value_in = new_byte;
      end else if (ctrl.shift_data) begin
         data_valid_in = nbr_data.valid;
         data_value_in = nbr_data.value;
      end

      scan_valid_in = scan_valid_ff;
      scan_value_in = scan_value_ff;
      if (ctrl.load) begin
         scan_valid_in = load_sel ? 1'b1 : data_valid_ff;
         scan_value_in = load_sel ? new_byte : data_value_ff;
      end else if (ctrl.shift_scan) begin
         scan_valid_in = nbr_scan.valid;
         scan_value_in = nbr_scan.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_valid_ff <= 1'b0;
         scan_valid_ff <= 1'b0;
      end else begin
         data_valid_ff <= data_valid_in;
         scan_valid_ff <= scan_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_value_ff <= data_value_in;
      scan_value_ff <= scan_value_in;
   end

   assign data_out.valid = data_valid_ff;
   assign data_out.value = data_value_ff;
   assign scan_out.valid = scan_valid_ff;
   assign scan_out.value = scan_value_ff;

   // held byte is not a pattern prefix byte at this position
   assign bad = scan_valid_ff && (past_len || (scan_value_ff != pat_byte));

endmodule

`default_nettype wire

FILE: src/stream_find_replace.sv
`default_nettype none

// channel  direction  tdata                                 tlast     tuser
// req_     in         in_byte[7:0]                          line_end  -
// rsp_     out        out_byte[7:0], replace_count[23:8]    run_last  line_done
// csr_     in         write port: csr_wr_en, csr_index, csr_wdata
//
// a transaction loads the byte into the cell row, slides the scan copy past k failed
// leading bytes, then sends n output bytes (up to 8 + k), each gated by the output
// register.
// rsp_ is held in an output register; the next req_ byte is taken once the sequencer is
// idle again: when that register takes the last result, or at once if nothing is sent.
// reset is synchronous; it empties the held bytes, clears the count and restores the
// pattern, text and length registers.

module stream_find_replace #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // in_byte
   input  wire logic                               req_tlast,  // line_end
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [23:0]                             rsp_tdata,  // out_byte, replace_count
   output logic                                    rsp_tlast,  // run_last
   output logic                                    rsp_tuser,  // line_done
   input  wire logic                               csr_wr_en,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FW = $clog2(PATTERN_MAX + 1);
   localparam int RW = $clog2(REPLACE_MAX + 1);
   localparam int RTW = 8 * REPLACE_MAX;
   localparam int CW = sfr_pkg::COUNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_REPL = 2'd3;

   logic [sfr_pkg::CSR_DATA_W-1:0] pattern_ff, pattern_in;
   logic [3:0]                     slen_reg_ff, slen_reg_in;
   logic [sfr_pkg::CSR_DATA_W-1:0] rtext_ff, rtext_in;
   logic [3:0]                     rlen_reg_ff, rlen_reg_in;

   logic [1:0]     state_ff, state_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [FW-1:0]  skip_ff, skip_in;
   logic [FW-1:0]  left_ff, left_in;
   logic [RW-1:0]  rleft_ff, rleft_in;
   logic           eol_ff, eol_in;
   logic [RTW-1:0] rsr_ff, rsr_in;
   logic [CW-1:0]  total_ff, total_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_line_ff, rsp_line_in;
   logic [CW-1:0]  rsp_count_ff, rsp_count_in;

   logic [FW-1:0]  slen_eff;
   logic [RW-1:0]  rlen_eff;
   logic [FW-1:0]  scan_fill;
   logic [FW-1:0]  shift_cnt;
   logic           prefix;
   logic           match;
   logic           out_free;
   logic           accept;
   logic           emit;

   sfr_pkg::cell_ctrl_type ctrl;
   sfr_pkg::slot_type      data_slot [PATTERN_MAX+1];
   sfr_pkg::slot_type      scan_slot [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] bad;
   logic [PATTERN_MAX-1:0] load_sel;
   logic [PATTERN_MAX-1:0] past_len;

   // configuration
   always_comb begin
      pattern_in = pattern_ff;
      slen_reg_in = slen_reg_ff;
      rtext_in = rtext_ff;
      rlen_reg_in = rlen_reg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sfr_pkg::CSR_SEARCH_PATTERN: pattern_in = csr_wdata;
            sfr_pkg::CSR_SEARCH_LENGTH: slen_reg_in = csr_wdata[3:0];
            sfr_pkg::CSR_REPLACE_TEXT: rtext_in = csr_wdata;
            sfr_pkg::CSR_REPLACE_LENGTH: rlen_reg_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (slen_reg_ff == 4'd0) begin
         slen_eff = FW'(1);
      end else if (slen_reg_ff > 4'(PATTERN_MAX)) begin
         slen_eff = FW'(PATTERN_MAX);
      end else begin
         slen_eff = FW'(slen_reg_ff);
      end
      if (rlen_reg_ff == 4'd0) begin
         rlen_eff = RW'(1);
      end else if (rlen_reg_ff > 4'(REPLACE_MAX)) begin
         rlen_eff = RW'(REPLACE_MAX);
      end else begin
         rlen_eff = RW'(rlen_reg_ff);
      end
   end

   // cell row
   assign data_slot[PATTERN_MAX] = '0;
   assign scan_slot[PATTERN_MAX] = '0;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      assign load_sel[i] = (fill_ff == FW'(i));
      assign past_len[i] = (FW'(i) >= slen_eff);

      sfr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .load_sel (load_sel[i]),
         .past_len (past_len[i]),
         .pat_byte (pattern_ff[8*i +: 8]),
         .new_byte (req_tdata),
         .nbr_data (data_slot[i+1]),
         .nbr_scan (scan_slot[i+1]),
         .data_out (data_slot[i]),
         .scan_out (scan_slot[i]),
         .bad      (bad[i])
      );
   end

   assign prefix = ~|bad;
   assign scan_fill = fill_ff - skip_ff;
   assign match = (scan_fill == slen_eff);
   assign shift_cnt = (!match && eol_ff) ? fill_ff : skip_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      skip_in = skip_ff;
      left_in = left_ff;
      rleft_in = rleft_ff;
      eol_in = eol_ff;
      rsr_in = rsr_ff;
      total_in = total_ff;
      ctrl = '0;
      emit = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_line_in = rsp_line_ff;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               if (fill_ff < FW'(PATTERN_MAX)) begin
                  fill_in = fill_ff + FW'(1);
               end
               eol_in = req_tlast;
               skip_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!prefix) begin
               ctrl.shift_scan = 1'b1;
               skip_in = skip_ff + FW'(1);
            end else begin
               left_in = shift_cnt;
               rleft_in = match ? rlen_eff : RW'(0);
               rsr_in = rtext_ff[RTW-1:0];
               fill_in = (match || eol_ff) ? FW'(0) : scan_fill;
               if (match && (total_ff != {CW{1'b1}})) begin
                  total_in = total_ff + CW'(1);
               end
               if (shift_cnt != FW'(0)) begin
                  state_in = ST_SHIFT;
               end else if (match) begin
                  state_in = ST_REPL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SHIFT: begin
            if (out_free) begin
               emit = 1'b1;
               ctrl.shift_data = 1'b1;
               rsp_byte_in = data_slot[0].value;
               rsp_last_in = (left_ff == FW'(1)) && (rleft_ff == RW'(0));
               rsp_line_in = (left_ff == FW'(1)) && (rleft_ff == RW'(0)) && eol_ff;
               rsp_count_in = total_ff;
               left_in = left_ff - FW'(1);
               if (left_ff == FW'(1)) begin
                  state_in = (rleft_ff != RW'(0)) ? ST_REPL : ST_IDLE;
               end
            end
         end
         ST_REPL: begin
            ctrl.clear = 1'b1;
            if (out_free) begin
               emit = 1'b1;
               rsp_byte_in = rsr_ff[7:0];
               rsp_last_in = (rleft_ff == RW'(1));
               rsp_line_in = (rleft_ff == RW'(1)) && eol_ff;
               rsp_count_in = total_ff;
               rsr_in = rsr_ff >> 8;
               rleft_in = rleft_ff - RW'(1);
               if (rleft_ff == RW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         slen_reg_ff <= 4'd1;
         rtext_ff <= '0;
         rlen_reg_ff <= 4'd1;
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         skip_ff <= '0;
         left_ff <= '0;
         rleft_ff <= '0;
         eol_ff <= 1'b0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff <= pattern_in;
         slen_reg_ff <= slen_reg_in;
         rtext_ff <= rtext_in;
         rlen_reg_ff <= rlen_reg_in;
         state_ff <= state_in;
         fill_ff <= fill_in;
         skip_ff <= skip_in;
         left_ff <= left_in;
         rleft_ff <= rleft_in;
         eol_ff <= eol_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsr_ff <= rsr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_line_ff <= rsp_line_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_count_ff, rsp_byte_ff};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_line_ff;

   // held bytes always leave room for the next one
   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < FW'(PATTERN_MAX)))
      else $error("fill at capacity while idle");

   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (skip_ff <= fill_ff))
      else $error("scan skipped past held bytes");

   a_shift_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (data_slot[0].valid && (left_ff != FW'(0))))
      else $error("shifting out an empty cell");

   a_repl_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPL) |-> (rleft_ff != RW'(0)))
      else $error("replacement with no bytes left");

endmodule

`default_nettype wire
